### rtl/irn_pkg.sv
// Shared constants and widths for the nearest-neighbor frame rotator.
`default_nettype none
package irn_pkg;

    // Frame store geometry
    localparam int MAX_COLS  = 512;
    localparam int MAX_ROWS  = 512;
    localparam int FRAC_BITS = 14;
    localparam int DEPTH     = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = $clog2(DEPTH);

    // Item field widths
    localparam int COL_W  = 9;
    localparam int ROW_W  = 9;
    localparam int PIX_W  = 8;
    localparam int SIZE_W = 10;
    localparam int TRIG_W = 16;

    // Datapath widths
    localparam int HALF_W = SIZE_W - 1;
    localparam int D_W    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
    localparam int P_W    = TRIG_W + D_W;
    localparam int SUM_W  = ((P_W > HALF_W + FRAC_BITS) ? P_W : HALF_W + FRAC_BITS) + 2;
    localparam int Q_W    = SUM_W - FRAC_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd3;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] RST_COLS = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] RST_ROWS = SIZE_W'(512);
    localparam logic [TRIG_W-1:0] RST_COS  = TRIG_W'(16384);
    localparam logic [TRIG_W-1:0] RST_SIN  = TRIG_W'(0);

endpackage
`default_nettype wire

### rtl/irn_item_if.sv
// Input channel: load and fetch items.
`default_nettype none
interface irn_item_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [irn_pkg::COL_W-1:0]    col;
    logic [irn_pkg::ROW_W-1:0]    row;
    logic [irn_pkg::PIX_W-1:0]    pixel_in;

    modport source (output valid, output opcode, output col, output row, output pixel_in,
                    input ready);
    modport sink   (input valid, input opcode, input col, input row, input pixel_in,
                    output ready);
endinterface
`default_nettype wire

### rtl/irn_result_if.sv
// Output channel: sampled pixels.
`default_nettype none
interface irn_result_if;
    logic                         valid;
    logic                         ready;
    logic [irn_pkg::PIX_W-1:0]    pixel_out;
    logic                         outside;

    modport source (output valid, output pixel_out, output outside, input ready);
    modport sink   (input valid, input pixel_out, input outside, output ready);
endinterface
`default_nettype wire

### rtl/irn_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module irn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/image_rotate_nearest.sv
// Nearest-neighbor frame rotator: top level with rotation pipeline and frame store.
// A fetch item passes capture, products, sum and address, and frame store access before
// its result is presented; a stalled result holds its stage.
// Throughput: one item per cycle while results are taken; the frame store has one write
// and one read port, both used in stage 4, so loads and fetches keep their order.
// Reset: configuration returns to 512 x 512, cos 1.0, sin 0; pipeline empties.
// The frame store is not cleared; a pixel reads as defined only once it was loaded.
`default_nettype none
module image_rotate_nearest (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [irn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [irn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    irn_item_if.sink                                i_item,
    irn_result_if.source                            o_result
);

    localparam int ADDR_W = irn_pkg::ADDR_W;
    localparam int SIZE_W = irn_pkg::SIZE_W;
    localparam int HALF_W = irn_pkg::HALF_W;
    localparam int D_W    = irn_pkg::D_W;
    localparam int P_W    = irn_pkg::P_W;
    localparam int SUM_W  = irn_pkg::SUM_W;
    localparam int Q_W    = irn_pkg::Q_W;
    localparam int FRAC   = irn_pkg::FRAC_BITS;

    // Configuration registers
    logic [SIZE_W-1:0]               r_cols;
    logic [SIZE_W-1:0]               r_rows;
    logic [irn_pkg::TRIG_W-1:0]      r_cos;
    logic [irn_pkg::TRIG_W-1:0]      r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= irn_pkg::RST_COLS;
            r_rows <= irn_pkg::RST_ROWS;
            r_cos  <= irn_pkg::RST_COS;
            r_sin  <= irn_pkg::RST_SIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                irn_pkg::CFG_COLS: r_cols <= i_cfg_data[SIZE_W-1:0];
                irn_pkg::CFG_ROWS: r_rows <= i_cfg_data[SIZE_W-1:0];
                irn_pkg::CFG_COS:  r_cos  <= i_cfg_data[irn_pkg::TRIG_W-1:0];
                irn_pkg::CFG_SIN:  r_sin  <= i_cfg_data[irn_pkg::TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size to 1..MAX and find the center
    logic [SIZE_W-1:0] cols_eff;
    logic [SIZE_W-1:0] rows_eff;
    logic [HALF_W-1:0] cx;
    logic [HALF_W-1:0] cy;

    always_comb begin
        if (r_cols == '0) begin
            cols_eff = SIZE_W'(1);
        end else if (32'(r_cols) > irn_pkg::MAX_COLS) begin
            cols_eff = SIZE_W'(irn_pkg::MAX_COLS);
        end else begin
            cols_eff = r_cols;
        end
        if (r_rows == '0) begin
            rows_eff = SIZE_W'(1);
        end else if (32'(r_rows) > irn_pkg::MAX_ROWS) begin
            rows_eff = SIZE_W'(irn_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_rows;
        end
        cx = cols_eff[SIZE_W-1:1];
        cy = rows_eff[SIZE_W-1:1];
    end

    // Stage handshake: a stage loads when empty or when the next one loads
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || o_result.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_item.ready = en1;

    logic acc;
    assign acc = i_item.valid && en1;

    // Stage 1: capture item and offsets from the center
    logic                           r_op1;
    logic [irn_pkg::COL_W-1:0]      r_col1;
    logic [irn_pkg::ROW_W-1:0]      r_row1;
    logic [irn_pkg::PIX_W-1:0]      r_pix1;
    logic signed [D_W-1:0]          r_dx1;
    logic signed [D_W-1:0]          r_dy1;
    logic signed [D_W-1:0]          n_dx1;
    logic signed [D_W-1:0]          n_dy1;

    assign n_dx1 = $signed(D_W'(i_item.col)) - $signed(D_W'(cx));
    assign n_dy1 = $signed(D_W'(i_item.row)) - $signed(D_W'(cy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op1  <= i_item.opcode;
            r_col1 <= i_item.col;
            r_row1 <= i_item.row;
            r_pix1 <= i_item.pixel_in;
            r_dx1  <= n_dx1;
            r_dy1  <= n_dy1;
        end
    end

    // Stage 2: the four rotation products
    logic                           r_op2;
    logic [irn_pkg::COL_W-1:0]      r_col2;
    logic [irn_pkg::ROW_W-1:0]      r_row2;
    logic [irn_pkg::PIX_W-1:0]      r_pix2;
    logic signed [P_W-1:0]          r_pcx;
    logic signed [P_W-1:0]          r_psx;
    logic signed [P_W-1:0]          r_psy;
    logic signed [P_W-1:0]          r_pcy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_op2  <= r_op1;
            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_pix2 <= r_pix1;
            r_pcx  <= P_W'($signed(r_cos)) * P_W'(r_dx1);
            r_psx  <= P_W'($signed(r_sin)) * P_W'(r_dx1);
            r_psy  <= P_W'($signed(r_sin)) * P_W'(r_dy1);
            r_pcy  <= P_W'($signed(r_cos)) * P_W'(r_dy1);
        end
    end

    // Stage 3: sum, truncate toward zero, bounds check, store address
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0]        mag_x;
    logic [SUM_W-1:0]        mag_y;
    logic [Q_W-1:0]          qx;
    logic [Q_W-1:0]          qy;
    logic                    out_x;
    logic                    out_y;
    logic                    ld_ok;
    logic [ADDR_W-1:0]       fetch_addr;
    logic [ADDR_W-1:0]       load_addr;

    always_comb begin
        sum_x = SUM_W'(r_pcx) - SUM_W'(r_psy)
              + $signed(SUM_W'({cx, {FRAC{1'b0}}}));
        sum_y = SUM_W'(r_psx) + SUM_W'(r_pcy)
              + $signed(SUM_W'({cy, {FRAC{1'b0}}}));
        mag_x = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
        mag_y = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
        qx    = mag_x[SUM_W-1:FRAC];
        qy    = mag_y[SUM_W-1:FRAC];
        // A negative sum under one pixel truncates to zero and stays inside
        out_x = (sum_x[SUM_W-1] && qx != '0) || (qx >= Q_W'(cols_eff));
        out_y = (sum_y[SUM_W-1] && qy != '0) || (qy >= Q_W'(rows_eff));
        fetch_addr = ADDR_W'(ADDR_W'(qy) * ADDR_W'(irn_pkg::MAX_COLS) + ADDR_W'(qx));
        load_addr  = ADDR_W'(ADDR_W'(r_row2) * ADDR_W'(irn_pkg::MAX_COLS)
                   + ADDR_W'(r_col2));
        ld_ok = (32'(r_col2) < irn_pkg::MAX_COLS) && (32'(r_row2) < irn_pkg::MAX_ROWS);
    end

    logic                           r_op3;
    logic [irn_pkg::PIX_W-1:0]      r_pix3;
    logic [ADDR_W-1:0]              r_addr3;
    logic                           r_out3;
    logic                           r_ldok3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_op3   <= r_op2;
            r_pix3  <= r_pix2;
            r_addr3 <= (r_op2 == irn_pkg::OP_FETCH) ? fetch_addr : load_addr;
            r_out3  <= out_x || out_y;
            r_ldok3 <= ld_ok;
        end
    end

    // Stage 4: frame store access; loads write and leave, fetches read
    logic                      mv3;
    logic                      ram_we;
    logic                      ram_re;
    logic [irn_pkg::PIX_W-1:0] ram_rdata;

    assign mv3    = r_v3 && en4;
    assign ram_we = mv3 && (r_op3 == irn_pkg::OP_LOAD) && r_ldok3;
    assign ram_re = mv3 && (r_op3 == irn_pkg::OP_FETCH) && !r_out3;

    irn_ram #(
        .WIDTH (irn_pkg::PIX_W),
        .DEPTH (irn_pkg::DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr3),
        .i_wdata (r_pix3),
        .i_re    (ram_re),
        .i_raddr (r_addr3),
        .o_rdata (ram_rdata)
    );

    logic r_out4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3 && (r_op3 == irn_pkg::OP_FETCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_out4 <= r_out3;
        end
    end

    // Present the result; outside the frame gives zero
    assign o_result.valid     = r_v4;
    assign o_result.outside   = r_out4;
    assign o_result.pixel_out = r_out4 ? '0 : ram_rdata;

endmodule
`default_nettype wire
